// ===== sv/ajb_pkg.sv =====
// ajb_pkg: shared widths, constants, register indexes, FSM state and
// the structs passed between the jitter buffer modules. No dependencies.
package ajb_pkg;

  localparam int DATA_W   = 64;
  localparam int DEPTH_W  = 7;
  localparam int CNT_W    = 32;
  localparam int TARGET_W = 6;
  localparam int WINDOW_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int FLOOR_W  = 8;
  localparam int CMP_W    = 9;   // common width for depth/target compares

  localparam logic [FLOOR_W-1:0]  FLOOR_NONE   = 8'hFF;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 6'd3;
  localparam logic [TARGET_W-1:0] TARGET_MIN   = 6'd2;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd250;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DEPTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAY,
    ST_NOFRAME
  } state_t;

  // per-result flags travelling beside the memory read data
  typedef struct packed {
    logic frame_valid;
    logic zero;
    logic last;
  } tag_t;

  // status fields attached to every result of a tick
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   received;
    logic [CNT_W-1:0]   underrun;
    logic [CNT_W-1:0]   dropped;
    logic [CNT_W-1:0]   trimmed;
  } stats_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-1){1'b0}}, n};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

// ===== sv/ajb_if.sv =====
// ajb_if: valid/ready channel interfaces for requests into the buffer
// and results out of it. Depends on ajb_pkg for field widths.
interface ajb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ajb_pkg::DATA_W-1:0] data_word;
  logic                       frame_end;

  modport source(output valid, kind, data_word, frame_end, input ready);
  modport sink(input valid, kind, data_word, frame_end, output ready);
endinterface

interface ajb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_valid;
  logic [ajb_pkg::DATA_W-1:0]  out_word;
  logic                        last_word;
  logic [ajb_pkg::DEPTH_W-1:0] depth;
  logic [ajb_pkg::CNT_W-1:0]   received_count;
  logic [ajb_pkg::CNT_W-1:0]   underrun_count;
  logic [ajb_pkg::CNT_W-1:0]   dropped_count;
  logic [ajb_pkg::CNT_W-1:0]   trimmed_count;

  modport source(output valid, frame_valid, out_word, last_word, depth,
                 received_count, underrun_count, dropped_count, trimmed_count,
                 input ready);
  modport sink(input valid, frame_valid, out_word, last_word, depth,
               received_count, underrun_count, dropped_count, trimmed_count,
               output ready);
endinterface

// ===== sv/ajb_ram.sv =====
// ajb_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data held when no read is enabled. No dependencies.
module ajb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2560
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ajb_ctrl.sv =====
// ajb_ctrl: ring bookkeeping, priming, trimming, statistics and the
// playout read sequencer. Depends on ajb_pkg and ajb_in_if.
module ajb_ctrl #(
  parameter int SLOTS       = 64,
  parameter int FRAME_WORDS = 40
) (
  input  logic                                     clk,
  input  logic                                     rst,
  ajb_in_if.sink                                   items,
  input  logic                                     cfg_we,
  input  logic [ajb_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [ajb_pkg::CFG_W-1:0]                cfg_data,
  output logic                                     fm_we,
  output logic [$clog2(SLOTS*FRAME_WORDS)-1:0]     fm_waddr,
  output logic [ajb_pkg::DATA_W-1:0]               fm_wdata,
  output logic                                     fm_re,
  output logic [$clog2(SLOTS*FRAME_WORDS)-1:0]     fm_raddr,
  output logic                                     lm_we,
  output logic [$clog2(SLOTS)-1:0]                 lm_waddr,
  output logic [$clog2(FRAME_WORDS+1)-1:0]         lm_wdata,
  output logic                                     lm_re,
  output logic [$clog2(SLOTS)-1:0]                 lm_raddr,
  input  logic [$clog2(FRAME_WORDS+1)-1:0]         lm_rdata,
  input  logic                                     q_space,
  output logic                                     q_load,
  output ajb_pkg::tag_t                            q_tag,
  output ajb_pkg::stats_t                          q_stats
);

  localparam int SW   = $clog2(SLOTS);
  localparam int SW1  = SW + 1;
  localparam int HW   = $clog2(SLOTS + 1);
  localparam int WW   = $clog2(FRAME_WORDS + 1);
  localparam int AW   = $clog2(SLOTS * FRAME_WORDS);
  localparam int KW   = ajb_pkg::CMP_W;
  localparam int HALF = SLOTS / 2;
  localparam int TW   = ajb_pkg::TARGET_W;

  // ring and window state
  logic [SW-1:0]                write_slot, write_slot_next;
  logic [SW-1:0]                read_slot, read_slot_next;
  logic [HW-1:0]                frames_held, frames_held_next;
  logic [WW-1:0]                word_in_frame, word_in_frame_next;
  logic                         is_priming, is_priming_next;
  logic [ajb_pkg::FLOOR_W-1:0]  window_floor, window_floor_next;
  logic [ajb_pkg::WINDOW_W-1:0] window_count, window_count_next;
  logic [ajb_pkg::CNT_W-1:0]    received, received_next;
  logic [ajb_pkg::CNT_W-1:0]    underrun, underrun_next;
  logic [ajb_pkg::CNT_W-1:0]    dropped, dropped_next;
  logic [ajb_pkg::CNT_W-1:0]    trimmed, trimmed_next;
  logic [TW-1:0]                target_depth;
  logic [ajb_pkg::WINDOW_W-1:0] drain_window;

  // playout sequencer
  ajb_pkg::state_t              state, state_next;
  logic [AW-1:0]                play_addr, play_addr_next;
  logic [WW-1:0]                play_idx, play_idx_next;

  logic                         accept, push, tick, no_frame;
  logic                         issue, idx_last, commit, drop;
  logic [HW-1:0]                held_v, held_c, h;
  logic [1:0]                   adv, trims;
  logic [ajb_pkg::FLOOR_W-1:0]  fl;
  logic [ajb_pkg::WINDOW_W-1:0] wc, win;
  logic [SW1-1:0]               rs_sum;
  logic [TW-1:0]                cfg_tgt;

  assign items.ready = (state == ajb_pkg::ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign push        = accept && !items.kind;
  assign tick        = accept && items.kind;
  assign no_frame    = is_priming || (frames_held == '0);
  assign issue       = (state == ajb_pkg::ST_PLAY) && q_space;
  assign idx_last    = (play_idx == WW'(FRAME_WORDS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ajb_pkg::ST_IDLE: begin
        if (tick) begin
          state_next = no_frame ? ajb_pkg::ST_NOFRAME : ajb_pkg::ST_PLAY;
        end
      end
      ajb_pkg::ST_PLAY: begin
        if (issue && idx_last) begin
          state_next = ajb_pkg::ST_IDLE;
        end
      end
      ajb_pkg::ST_NOFRAME: begin
        if (q_space) begin
          state_next = ajb_pkg::ST_IDLE;
        end
      end
      default: state_next = ajb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    fm_re          = issue;
    fm_raddr       = play_addr;
    q_load         = 1'b0;
    q_tag          = '0;
    play_addr_next = play_addr;
    play_idx_next  = play_idx;
    unique case (state)
      ajb_pkg::ST_IDLE: begin
        if (tick) begin
          play_addr_next = AW'(read_slot) * AW'(FRAME_WORDS);
          play_idx_next  = '0;
        end
      end
      ajb_pkg::ST_PLAY: begin
        q_load            = q_space;
        q_tag.frame_valid = 1'b1;
        q_tag.zero        = (play_idx >= lm_rdata);  // past a short frame's end
        q_tag.last        = idx_last;
        if (issue) begin
          play_addr_next = play_addr + AW'(1);
          play_idx_next  = play_idx + WW'(1);
        end
      end
      ajb_pkg::ST_NOFRAME: begin
        q_load     = q_space;
        q_tag.zero = 1'b1;
        q_tag.last = 1'b1;
      end
      default: ;
    endcase
  end

  assign q_stats.depth    = ajb_pkg::DEPTH_W'(frames_held);
  assign q_stats.received = received;
  assign q_stats.underrun = underrun;
  assign q_stats.dropped  = dropped;
  assign q_stats.trimmed  = trimmed;

  // push and tick bookkeeping
  always_comb begin
    write_slot_next    = write_slot;
    read_slot_next     = read_slot;
    frames_held_next   = frames_held;
    word_in_frame_next = word_in_frame;
    is_priming_next    = is_priming;
    window_floor_next  = window_floor;
    window_count_next  = window_count;
    received_next      = received;
    underrun_next      = underrun;
    dropped_next       = dropped;
    trimmed_next       = trimmed;

    fm_we    = push;
    fm_waddr = AW'(write_slot) * AW'(FRAME_WORDS) + AW'(word_in_frame);
    fm_wdata = items.data_word;
    lm_we    = 1'b0;
    lm_waddr = write_slot;
    lm_wdata = word_in_frame + WW'(1);
    lm_re    = 1'b0;
    lm_raddr = read_slot;

    drop   = (word_in_frame == '0) && (frames_held == HW'(SLOTS));
    commit = items.frame_end || (word_in_frame == WW'(FRAME_WORDS - 1));
    held_v = drop ? frames_held - HW'(1) : frames_held;
    held_c = held_v + HW'(1);

    h      = frames_held - HW'(1);
    adv    = 2'd1;
    trims  = 2'd0;
    fl     = window_floor;
    wc     = window_count + ajb_pkg::WINDOW_W'(1);
    win    = (drain_window == '0) ? ajb_pkg::WINDOW_W'(1) : drain_window;
    rs_sum = '0;

    if (push) begin
      if (drop) begin
        // full ring: oldest frame goes before the new one starts
        read_slot_next = (read_slot == SW'(SLOTS - 1)) ? '0 : read_slot + SW'(1);
        dropped_next   = ajb_pkg::sat_add(dropped, 2'd1);
      end
      frames_held_next = held_v;
      if (commit) begin
        lm_we              = 1'b1;
        word_in_frame_next = '0;
        write_slot_next    = (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + SW'(1);
        frames_held_next   = held_c;
        received_next      = ajb_pkg::sat_add(received, 2'd1);
        if (is_priming && (KW'(held_c) >= KW'(target_depth))) begin
          is_priming_next = 1'b0;
        end
      end else begin
        word_in_frame_next = word_in_frame + WW'(1);
      end
    end

    if (tick) begin
      if (no_frame) begin
        if (!is_priming) begin
          underrun_next = ajb_pkg::sat_add(underrun, 2'd1);
        end
      end else begin
        lm_re = 1'b1;
        if (h == '0) begin
          is_priming_next   = 1'b1;
          window_count_next = '0;
          window_floor_next = ajb_pkg::FLOOR_NONE;
        end else begin
          if (KW'(h) < KW'(window_floor)) begin
            fl = ajb_pkg::FLOOR_W'(h);
          end
          if (wc >= win) begin
            // window closed: trim if depth never fell to the target
            if ((fl != ajb_pkg::FLOOR_NONE) && (KW'(fl) > KW'(target_depth))) begin
              h     = h - HW'(1);
              adv   = adv + 2'd1;
              trims = trims + 2'd1;
            end
            wc = '0;
            fl = ajb_pkg::FLOOR_NONE;
          end
          if (KW'(h) > (KW'(target_depth) << 2)) begin
            h     = h - HW'(1);
            adv   = adv + 2'd1;
            trims = trims + 2'd1;
          end
          window_count_next = wc;
          window_floor_next = fl;
        end
        frames_held_next = h;
        rs_sum = SW1'(read_slot) + SW1'(adv);
        if (rs_sum >= SW1'(SLOTS)) begin
          rs_sum = rs_sum - SW1'(SLOTS);
        end
        read_slot_next = rs_sum[SW-1:0];
        trimmed_next   = ajb_pkg::sat_add(trimmed, trims);
      end
    end
  end

  // clamp of a target write to 2..SLOTS/2
  always_comb begin
    cfg_tgt = cfg_data[TW-1:0];
    if (cfg_tgt < ajb_pkg::TARGET_MIN) begin
      cfg_tgt = ajb_pkg::TARGET_MIN;
    end
    if ({1'b0, cfg_tgt} > (TW+1)'(HALF)) begin
      cfg_tgt = TW'(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ajb_pkg::ST_IDLE;
      write_slot    <= '0;
      read_slot     <= '0;
      frames_held   <= '0;
      word_in_frame <= '0;
      is_priming    <= 1'b1;
      window_floor  <= ajb_pkg::FLOOR_NONE;
      window_count  <= '0;
      received      <= '0;
      underrun      <= '0;
      dropped       <= '0;
      trimmed       <= '0;
      target_depth  <= ajb_pkg::TARGET_RESET;
      drain_window  <= ajb_pkg::WINDOW_RESET;
      play_addr     <= '0;
      play_idx      <= '0;
    end else begin
      state         <= state_next;
      write_slot    <= write_slot_next;
      read_slot     <= read_slot_next;
      frames_held   <= frames_held_next;
      word_in_frame <= word_in_frame_next;
      is_priming    <= is_priming_next;
      window_floor  <= window_floor_next;
      window_count  <= window_count_next;
      received      <= received_next;
      underrun      <= underrun_next;
      dropped       <= dropped_next;
      trimmed       <= trimmed_next;
      play_addr     <= play_addr_next;
      play_idx      <= play_idx_next;
      if (cfg_we) begin
        unique case (cfg_index)
          ajb_pkg::REG_TARGET_DEPTH: target_depth <= cfg_tgt;
          ajb_pkg::REG_DRAIN_WINDOW: drain_window <= cfg_data;
        endcase
      end
    end
  end

endmodule

// ===== sv/ajb_out_stage.sv =====
// ajb_out_stage: two-entry elastic result path (memory read register plus
// output register) that drives the result channel. Depends on ajb_pkg, ajb_out_if.
module ajb_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_load,
  input  ajb_pkg::tag_t              q_tag,
  input  ajb_pkg::stats_t            q_stats,
  input  logic [ajb_pkg::DATA_W-1:0] rdata,
  output logic                       q_space,
  ajb_out_if.source                  results
);

  logic            q1_vld;
  ajb_pkg::tag_t   q1_tag;
  ajb_pkg::stats_t q1_stats;
  logic            out_vld;
  logic            move;

  assign move    = q1_vld && (!out_vld || results.ready);
  assign q_space = !q1_vld || move;
  assign results.valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (q_load) begin
        q1_vld <= 1'b1;
      end else if (move) begin
        q1_vld <= 1'b0;
      end
      if (move) begin
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      q1_tag   <= q_tag;
      q1_stats <= q_stats;
    end
    if (move) begin
      results.frame_valid    <= q1_tag.frame_valid;
      results.out_word       <= q1_tag.zero ? '0 : rdata;
      results.last_word      <= q1_tag.last;
      results.depth          <= q1_stats.depth;
      results.received_count <= q1_stats.received;
      results.underrun_count <= q1_stats.underrun;
      results.dropped_count  <= q1_stats.dropped;
      results.trimmed_count  <= q1_stats.trimmed;
    end
  end

endmodule

// ===== sv/audio_jitter_buffer.sv =====
// audio_jitter_buffer: top level of the frame ring jitter buffer.
// Depends on ajb_pkg, ajb_if, ajb_ram, ajb_ctrl and ajb_out_stage.
//
// Usage:
//  - items: requests, kind 0 = one word of a pushed frame (data_word,
//    frame_end marks the last word), kind 1 = playout tick.
//  - results: FRAME_WORDS words per tick that plays a frame (last_word on
//    the final one), or one word with frame_valid 0 while priming or empty.
//    Every result of a tick carries depth and the four saturating counters
//    as they stand after that tick.
//  - cfg_we/cfg_index/cfg_data: register 0 target_depth (clamped to
//    2..SLOTS/2), register 1 drain_window. Write only while idle.
// Sequencing:
//  - A push gives no result.
//  - A tick that plays a frame holds the request side for a bookkeeping
//    step, then one frame memory read per cycle while the result path has space.
//    The first result passes the state, memory read and output registers.
//  - A tick with no frame holds the request side until the result path has room.
// Reset (rst, synchronous): ring empty, priming, counters zero, target 3,
// window 250. Frame memory contents are not cleared; no clearing pass.
// A stalled result side stops the frame reads once the two result
// registers are full; the next request is taken after the last read issues.
module audio_jitter_buffer #(
  parameter int SLOTS       = 64,
  parameter int FRAME_WORDS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  ajb_in_if.sink                        items,
  ajb_out_if.source                     results,
  input  logic                          cfg_we,
  input  logic [ajb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ajb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int WW = $clog2(FRAME_WORDS + 1);
  localparam int AW = $clog2(SLOTS * FRAME_WORDS);

  // frame memory ports
  logic                       fm_we, fm_re;
  logic [AW-1:0]              fm_waddr, fm_raddr;
  logic [ajb_pkg::DATA_W-1:0] fm_wdata, fm_rdata;

  // per-slot word count memory (short frames play zeros past their end)
  logic                       lm_we, lm_re;
  logic [SW-1:0]              lm_waddr, lm_raddr;
  logic [WW-1:0]              lm_wdata, lm_rdata;

  // result path handoff
  logic                       q_space, q_load;
  ajb_pkg::tag_t              q_tag;
  ajb_pkg::stats_t            q_stats;

  ajb_ram #(
    .WIDTH (ajb_pkg::DATA_W),
    .DEPTH (SLOTS * FRAME_WORDS)
  ) u_frame_mem (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .re    (fm_re),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  ajb_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_len_mem (
    .clk   (clk),
    .we    (lm_we),
    .waddr (lm_waddr),
    .wdata (lm_wdata),
    .re    (lm_re),
    .raddr (lm_raddr),
    .rdata (lm_rdata)
  );

  // ring state, trimming and the read sequencer
  ajb_ctrl #(
    .SLOTS       (SLOTS),
    .FRAME_WORDS (FRAME_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fm_we     (fm_we),
    .fm_waddr  (fm_waddr),
    .fm_wdata  (fm_wdata),
    .fm_re     (fm_re),
    .fm_raddr  (fm_raddr),
    .lm_we     (lm_we),
    .lm_waddr  (lm_waddr),
    .lm_wdata  (lm_wdata),
    .lm_re     (lm_re),
    .lm_raddr  (lm_raddr),
    .lm_rdata  (lm_rdata),
    .q_space   (q_space),
    .q_load    (q_load),
    .q_tag     (q_tag),
    .q_stats   (q_stats)
  );

  // frame memory read register + output register
  ajb_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .q_load  (q_load),
    .q_tag   (q_tag),
    .q_stats (q_stats),
    .rdata   (fm_rdata),
    .q_space (q_space),
    .results (results)
  );

endmodule
